>>> design/dft_pkg.sv
// Shared constants and types for the DShot frame transmitter core.
// No dependencies.
package dft_pkg;

  parameter int unsigned MotorsDefault = 4;

  parameter int unsigned FrameBits  = 16;
  parameter int unsigned RawW       = 11;
  parameter int unsigned MotorW     = 2;
  parameter int unsigned HighTimeW  = 16;
  parameter int unsigned CfgAddrW   = 2;

  parameter logic [RawW-1:0] RawOffset = 11'd48;
  parameter logic [RawW-1:0] RawCap    = 11'd2047;

  parameter logic [HighTimeW-1:0] OneHighReset  = 16'd120;
  parameter logic [HighTimeW-1:0] ZeroHighReset = 16'd60;

  typedef enum logic [1:0] {
    CmdSpeed = 2'd0,
    CmdOrder = 2'd1,
    CmdDone  = 2'd2
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegOneHigh   = 2'd0,
    RegZeroHigh  = 2'd1,
    RegTelemetry = 2'd2
  } cfg_reg_e;

  typedef logic [FrameBits-1:0] frame_t;

  function automatic frame_t build_frame(logic [RawW-1:0] raw, logic tel);
    logic [11:0] f;
    logic [3:0]  sum;
    f   = {tel, raw};
    sum = f[3:0] ^ f[7:4] ^ f[11:8];
    return {sum, f};
  endfunction

endpackage

>>> design/dshot_frame_transmitter_core.sv
// DShot frame transmitter core: request decode, per-motor slot memories and bit emitter.
// Depends on dft_pkg.
//
// Each accepted request is registered into the decision stage, where it reads the
// per-motor pending flags and the parked frames from the slot memories (registered read,
// forwarded against the write of the item ahead). A request that starts a frame or is
// dropped hands its result run to a single bit-serial emitter: a frame gives sixteen
// transfers, MSB first, one per cycle while m_axis_tready is high; a dropped command
// gives one transfer flagged in tuser. A request with no result does not wait for the
// emitter. The emitter sets the sustained rate of frame-starting requests, and the next
// run starts in the cycle after the last transfer of the previous one. High times are
// taken from the configuration at emission.
module dshot_frame_transmitter_core #(
  parameter int unsigned MOTORS = dft_pkg::MotorsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] motor, [12:2] value, [15:13] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // bit high-time stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] out_motor, [17:2] pulse_high, [23:18] zero
  output logic        m_axis_tlast,   // last_bit
  output logic        m_axis_tuser    // dropped
);

  localparam int unsigned MotorIdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int unsigned CntW      = $clog2(dft_pkg::FrameBits);
  localparam logic [CntW-1:0] CntLast = CntW'(dft_pkg::FrameBits - 1);

  logic [dft_pkg::HighTimeW-1:0] one_high_q, zero_high_q;
  logic                          tel_q;

  logic [MOTORS-1:0] busy_q, spdw_q, ordw_q;
  dft_pkg::frame_t   spd_mem [MOTORS];
  dft_pkg::frame_t   ord_mem [MOTORS];
  dft_pkg::frame_t   spd_rd_q, ord_rd_q;

  logic                      s1_valid_q;
  logic [1:0]                s1_cmd_q;
  logic [dft_pkg::MotorW-1:0] s1_motor_q;
  logic [dft_pkg::RawW-1:0]  s1_value_q;

  logic                      em_act_q;
  logic                      em_drop_q;
  dft_pkg::frame_t           em_frame_q;
  logic [CntW-1:0]           em_cnt_q;
  logic [dft_pkg::MotorW-1:0] em_motor_q;

  logic                      in_xfer, out_xfer, em_last, em_free;
  logic [dft_pkg::MotorW-1:0] in_motor;
  logic [MotorIdxW-1:0]      in_addr, s1_addr;
  logic                      s1_in_range;
  logic [dft_pkg::RawW:0]    raw_sum;
  logic [dft_pkg::RawW-1:0]  raw_spd;
  dft_pkg::frame_t           frame_spd, frame_ord, load_frame;
  logic                      need_out, load_drop, s1_go;
  logic                      spd_we, ord_we;
  logic                      set_busy, clr_busy, set_spdw, clr_spdw, set_ordw, clr_ordw;

  assign cfg_ready_o = 1'b1;

  assign in_motor = s_axis_tdata[1:0];
  assign in_addr  = MotorIdxW'(in_motor);
  assign s1_addr  = MotorIdxW'(s1_motor_q);
  assign s1_in_range = 32'(s1_motor_q) < MOTORS;

  assign raw_sum   = {1'b0, s1_value_q} + {1'b0, dft_pkg::RawOffset};
  assign raw_spd   = raw_sum[dft_pkg::RawW] ? dft_pkg::RawCap : raw_sum[dft_pkg::RawW-1:0];
  assign frame_spd = dft_pkg::build_frame(raw_spd, tel_q);
  assign frame_ord = dft_pkg::build_frame(s1_value_q, tel_q);

  always_comb begin
    need_out   = 1'b0;
    load_drop  = 1'b0;
    load_frame = frame_spd;
    spd_we     = 1'b0;
    ord_we     = 1'b0;
    set_busy   = 1'b0;
    clr_busy   = 1'b0;
    set_spdw   = 1'b0;
    clr_spdw   = 1'b0;
    set_ordw   = 1'b0;
    clr_ordw   = 1'b0;
    if (s1_valid_q && s1_in_range) begin
      case (s1_cmd_q)
        dft_pkg::CmdSpeed: begin
          if (!busy_q[s1_addr]) begin
            need_out = 1'b1;
            set_busy = 1'b1;
          end else begin
            spd_we   = 1'b1;
            set_spdw = 1'b1;
          end
        end
        dft_pkg::CmdOrder: begin
          load_frame = frame_ord;
          if (!busy_q[s1_addr]) begin
            need_out = 1'b1;
            set_busy = 1'b1;
          end else if (ordw_q[s1_addr]) begin
            need_out  = 1'b1;
            load_drop = 1'b1;
          end else begin
            ord_we   = 1'b1;
            set_ordw = 1'b1;
          end
        end
        dft_pkg::CmdDone: begin
          if (ordw_q[s1_addr]) begin
            need_out   = 1'b1;
            load_frame = ord_rd_q;
            clr_ordw   = 1'b1;
          end else if (spdw_q[s1_addr]) begin
            need_out   = 1'b1;
            load_frame = spd_rd_q;
            clr_spdw   = 1'b1;
          end else begin
            clr_busy = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign em_last  = em_drop_q || (em_cnt_q == CntLast);
  assign em_free  = !em_act_q || (em_last && m_axis_tready);
  assign s1_go    = s1_valid_q && (!need_out || em_free);

  assign s_axis_tready = !s1_valid_q || s1_go;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= dft_pkg::OneHighReset;
      zero_high_q <= dft_pkg::ZeroHighReset;
      tel_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        dft_pkg::RegOneHigh:   one_high_q  <= cfg_wdata_i;
        dft_pkg::RegZeroHigh:  zero_high_q <= cfg_wdata_i;
        dft_pkg::RegTelemetry: tel_q       <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      spdw_q <= '0;
      ordw_q <= '0;
    end else if (s1_go) begin
      if (set_busy) busy_q[s1_addr] <= 1'b1;
      if (clr_busy) busy_q[s1_addr] <= 1'b0;
      if (set_spdw) spdw_q[s1_addr] <= 1'b1;
      if (clr_spdw) spdw_q[s1_addr] <= 1'b0;
      if (set_ordw) ordw_q[s1_addr] <= 1'b1;
      if (clr_ordw) ordw_q[s1_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && spd_we) begin
      spd_mem[s1_addr] <= frame_spd;
    end
    if (s1_go && ord_we) begin
      ord_mem[s1_addr] <= frame_ord;
    end
    if (in_xfer) begin
      spd_rd_q <= (s1_go && spd_we && s1_addr == in_addr) ? frame_spd : spd_mem[in_addr];
      ord_rd_q <= (s1_go && ord_we && s1_addr == in_addr) ? frame_ord : ord_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q   <= s_axis_tuser;
      s1_motor_q <= in_motor;
      s1_value_q <= s_axis_tdata[12:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_act_q <= 1'b0;
      em_cnt_q <= '0;
    end else if (s1_go && need_out) begin
      em_act_q <= 1'b1;
      em_cnt_q <= '0;
    end else if (out_xfer) begin
      em_act_q <= !em_last;
      em_cnt_q <= em_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && need_out) begin
      em_frame_q <= load_frame;
      em_drop_q  <= load_drop;
      em_motor_q <= s1_motor_q;
    end else if (out_xfer) begin
      em_frame_q <= {em_frame_q[dft_pkg::FrameBits-2:0], 1'b0};
    end
  end

  assign m_axis_tvalid = em_act_q;
  assign m_axis_tdata  = {6'b0,
                          em_drop_q ? 16'd0 :
                          (em_frame_q[dft_pkg::FrameBits-1] ? one_high_q : zero_high_q),
                          em_motor_q};
  assign m_axis_tlast  = em_last;
  assign m_axis_tuser  = em_drop_q;

endmodule
